FILE: rtl/core/hpack_dynamic_table_manager_assert.svh
// Assertion macros shared by the table manager modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef HPACK_DYNAMIC_TABLE_MANAGER_ASSERT_SVH
`define HPACK_DYNAMIC_TABLE_MANAGER_ASSERT_SVH

// Same-cycle implication.
`define HDTM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HDTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hdtm_pkg.sv
`timescale 1ns / 1ps

package hdtm_pkg;

  localparam int STATIC_ENTRIES = 61;
  localparam int ENTRY_OVERHEAD = 32;

  localparam int REQ_W   = 2;
  localparam int INDEX_W = 8;
  localparam int LEN_W   = 16;
  localparam int MAXB_W  = 13;
  localparam int SIDX_W  = 6;
  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 8;
  localparam int BYTES_W = 13;
  localparam int SIZE_W  = 18;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESIZE = 2'd2;

  typedef struct packed {
    logic capture;
    logic drop;
    logic clear;
    logic append;
    logic finish;
  } hdtm_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             oversize;
    logic             evict_needed;
  } hdtm_status_t;

endpackage

FILE: rtl/core/hdtm_ctrl.sv
`timescale 1ns / 1ps
`include "hpack_dynamic_table_manager_assert.svh"

module hdtm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  hdtm_pkg::hdtm_status_t st,
  output hdtm_pkg::hdtm_cmd_t    cmd
);
  import hdtm_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_WORK = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_WORK;
        end
      end
      S_WORK: begin
        case (st.req)
          REQ_INSERT: begin
            if (st.oversize) begin
              if (out_free) begin
                cmd.clear  = 1'b1;
                cmd.finish = 1'b1;
              end
            end else if (st.evict_needed) begin
              cmd.drop = 1'b1;
            end else if (out_free) begin
              cmd.append = 1'b1;
              cmd.finish = 1'b1;
            end
          end
          REQ_RESIZE: begin
            if (st.evict_needed) begin
              cmd.drop = 1'b1;
            end else if (out_free) begin
              cmd.finish = 1'b1;
            end
          end
          default: begin
            if (out_free) begin
              cmd.finish = 1'b1;
            end
          end
        endcase
        if (cmd.finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HDTM_ASSERT_IMPL(a_idle_no_update, state == S_IDLE, !(cmd.drop || cmd.append || cmd.clear), "table changed while idle")
  `HDTM_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid && state == S_IDLE, "finished item not presented")
  `HDTM_ASSERT_IMPL(a_finish_free, cmd.finish, out_free, "result overwrote a pending item")

endmodule

FILE: rtl/core/hdtm_datapath.sv
`timescale 1ns / 1ps
`include "hpack_dynamic_table_manager_assert.svh"

module hdtm_datapath #(
  parameter int MAX_TABLE_BYTES = 4096,
  parameter int RING_SLOTS      = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  hdtm_pkg::hdtm_cmd_t            cmd,
  output hdtm_pkg::hdtm_status_t         st,
  input  logic [hdtm_pkg::REQ_W-1:0]     req_type,
  input  logic [hdtm_pkg::INDEX_W-1:0]   header_index,
  input  logic [hdtm_pkg::LEN_W-1:0]     name_len,
  input  logic [hdtm_pkg::LEN_W-1:0]     value_len,
  input  logic [hdtm_pkg::MAXB_W-1:0]    new_max_bytes,
  output logic                           status,
  output logic                           is_static,
  output logic [hdtm_pkg::SIDX_W-1:0]    static_index,
  output logic [hdtm_pkg::SLOT_W-1:0]    slot,
  output logic                           cleared,
  output logic [hdtm_pkg::COUNT_W-1:0]   evicted,
  output logic [hdtm_pkg::COUNT_W-1:0]   entry_count,
  output logic [hdtm_pkg::BYTES_W-1:0]   table_bytes
);
  import hdtm_pkg::*;

  localparam int BW = $clog2(MAX_TABLE_BYTES + 1);
  localparam int IW = $clog2(RING_SLOTS);
  localparam int CW = $clog2(RING_SLOTS + 1);
  localparam int DW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int LW = (BW > MAXB_W) ? BW : MAXB_W;

  logic [REQ_W-1:0]   req;
  logic [INDEX_W-1:0] idx;
  logic [SIZE_W-1:0]  size;
  logic [BW-1:0]      limit_bytes;
  logic [CW-1:0]      held_entries;
  logic [BW-1:0]      held_bytes;
  logic [IW-1:0]      oldest_slot;
  logic [CW-1:0]      evict_count;
  logic [BW-1:0]      oldest_size;
  logic [BW-1:0]      size_ring [RING_SLOTS];

  logic [CW-1:0]      held_entries_next;
  logic [BW-1:0]      held_bytes_next;
  logic [IW-1:0]      oldest_slot_next;
  logic [SIZE_W-1:0]  size_sum;
  logic [BW-1:0]      limit_sat;
  logic [BW-1:0]      target;
  logic               oversize;
  logic               ring_full;
  logic [IW-1:0]      oldest_inc;
  logic [BW-1:0]      bytes_after_drop;
  logic [IW:0]        app_sum;
  logic [IW-1:0]      app_slot;
  logic [DW-1:0]      dyn;
  logic               dyn_hit;
  logic [IW:0]        lk_sum;
  logic [IW-1:0]      lk_slot;
  logic               idx_static;

  assign size_sum = SIZE_W'(name_len) + SIZE_W'(value_len) + SIZE_W'(ENTRY_OVERHEAD);
  assign limit_sat = (LW'(new_max_bytes) > LW'(MAX_TABLE_BYTES)) ?
                     BW'(MAX_TABLE_BYTES) : BW'(new_max_bytes);

  assign oversize  = size > SIZE_W'(limit_bytes);
  assign target    = limit_bytes - BW'(size);
  assign ring_full = held_entries >= CW'(RING_SLOTS);

  always_comb begin
    st.req      = req;
    st.oversize = oversize;
    if (req == REQ_INSERT) begin
      st.evict_needed = (held_entries != '0) && ((held_bytes > target) || ring_full);
    end else begin
      st.evict_needed = (held_entries != '0) && (held_bytes > limit_bytes);
    end
  end

  assign oldest_inc = (oldest_slot == IW'(RING_SLOTS - 1)) ? '0 : oldest_slot + IW'(1);
  assign bytes_after_drop = (oldest_size > held_bytes) ? '0 : held_bytes - oldest_size;

  assign app_sum  = (IW+1)'(oldest_slot) + (IW+1)'(held_entries);
  assign app_slot = (app_sum >= (IW+1)'(RING_SLOTS)) ?
                    IW'(app_sum - (IW+1)'(RING_SLOTS)) : IW'(app_sum);

  assign idx_static = (idx != '0) && (idx <= INDEX_W'(STATIC_ENTRIES));
  assign dyn        = DW'(idx) - DW'(STATIC_ENTRIES);
  assign dyn_hit    = (idx > INDEX_W'(STATIC_ENTRIES)) && (dyn <= DW'(held_entries));
  assign lk_sum     = (IW+1)'(oldest_slot) + (IW+1)'(held_entries) - (IW+1)'(dyn);
  assign lk_slot    = (lk_sum >= (IW+1)'(RING_SLOTS)) ?
                      IW'(lk_sum - (IW+1)'(RING_SLOTS)) : IW'(lk_sum);

  always_comb begin
    held_entries_next = held_entries;
    held_bytes_next   = held_bytes;
    oldest_slot_next  = oldest_slot;
    if (cmd.clear) begin
      held_entries_next = '0;
      held_bytes_next   = '0;
      oldest_slot_next  = '0;
    end else if (cmd.drop) begin
      held_entries_next = held_entries - CW'(1);
      held_bytes_next   = bytes_after_drop;
      oldest_slot_next  = oldest_inc;
    end else if (cmd.append) begin
      held_entries_next = held_entries + CW'(1);
      held_bytes_next   = held_bytes + BW'(size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_entries <= '0;
      held_bytes   <= '0;
      oldest_slot  <= '0;
      limit_bytes  <= BW'(MAX_TABLE_BYTES);
    end else begin
      held_entries <= held_entries_next;
      held_bytes   <= held_bytes_next;
      oldest_slot  <= oldest_slot_next;
      if (cmd.capture && (req_type == REQ_RESIZE)) begin
        limit_bytes <= limit_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req         <= req_type;
      idx         <= header_index;
      size        <= size_sum;
      evict_count <= '0;
    end else if (cmd.drop) begin
      evict_count <= evict_count + CW'(1);
    end
  end

  // The read port follows the next oldest slot, so the oldest size is ready
  // in every cycle; an append to that same slot is forwarded.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      size_ring[app_slot] <= BW'(size);
    end
    if (cmd.append && (app_slot == oldest_slot_next)) begin
      oldest_size <= BW'(size);
    end else begin
      oldest_size <= size_ring[oldest_slot_next];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= 1'b0;
      is_static    <= 1'b0;
      static_index <= '0;
      slot         <= '0;
      cleared      <= cmd.clear;
      evicted      <= cmd.clear ? COUNT_W'(held_entries) : COUNT_W'(evict_count);
      entry_count  <= COUNT_W'(held_entries_next);
      table_bytes  <= BYTES_W'(held_bytes_next);
      if (req == REQ_LOOKUP) begin
        if (idx_static) begin
          is_static    <= 1'b1;
          static_index <= SIDX_W'(idx);
        end else if (dyn_hit) begin
          slot <= SLOT_W'(lk_slot);
        end else begin
          status <= 1'b1;
        end
      end else if (cmd.append) begin
        slot <= SLOT_W'(app_slot);
      end
    end
  end

  `HDTM_ASSERT_IMPL(a_held_range, 1'b1, held_entries <= CW'(RING_SLOTS), "entry count past ring size")
  `HDTM_ASSERT_IMPL(a_empty_no_bytes, held_entries == '0, held_bytes == '0, "empty table holds bytes")
  `HDTM_ASSERT_IMPL(a_drop_nonempty, cmd.drop, held_entries != '0, "eviction from an empty table")

endmodule

FILE: rtl/core/hpack_dynamic_table_manager.sv
// A result is registered once its item is captured and the ring walk has dropped each
// entry to evict; it waits while the output holds an earlier result under stall.
// A new item is taken only after the last one's result is registered; an insert or size
// update that evicts walks the ring, which reads one ring size a cycle.
// Reset clears the counts and sets the limit to MAX_TABLE_BYTES; the ring is not swept.
`timescale 1ns / 1ps

module hpack_dynamic_table_manager #(
  parameter int MAX_TABLE_BYTES = 4096,
  parameter int RING_SLOTS      = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hdtm_pkg::REQ_W-1:0]     req_type,
  input  logic [hdtm_pkg::INDEX_W-1:0]   header_index,
  input  logic [hdtm_pkg::LEN_W-1:0]     name_len,
  input  logic [hdtm_pkg::LEN_W-1:0]     value_len,
  input  logic [hdtm_pkg::MAXB_W-1:0]    new_max_bytes,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           status,
  output logic                           is_static,
  output logic [hdtm_pkg::SIDX_W-1:0]    static_index,
  output logic [hdtm_pkg::SLOT_W-1:0]    slot,
  output logic                           cleared,
  output logic [hdtm_pkg::COUNT_W-1:0]   evicted,
  output logic [hdtm_pkg::COUNT_W-1:0]   entry_count,
  output logic [hdtm_pkg::BYTES_W-1:0]   table_bytes
);
  import hdtm_pkg::*;

  hdtm_cmd_t    cmd;
  hdtm_status_t st;

  hdtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  hdtm_datapath #(
    .MAX_TABLE_BYTES (MAX_TABLE_BYTES),
    .RING_SLOTS      (RING_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .req_type      (req_type),
    .header_index  (header_index),
    .name_len      (name_len),
    .value_len     (value_len),
    .new_max_bytes (new_max_bytes),
    .status        (status),
    .is_static     (is_static),
    .static_index  (static_index),
    .slot          (slot),
    .cleared       (cleared),
    .evicted       (evicted),
    .entry_count   (entry_count),
    .table_bytes   (table_bytes)
  );

endmodule
